>>> rtl/lfpd_pkg.sv
package lfpd_pkg;

  // Fixed point position of all Q.12 quantities.
  localparam int FRAC_BITS       = 12;
  localparam int SAMPLE_BITS_DEF = 12;

  // Register widths
  localparam int THR_W  = 12;
  localparam int GAIN_W = 16;
  localparam int BASE_W = 13;
  localparam int LIM_W  = 18;

  // Datapath widths
  localparam int ERR_W   = FRAC_BITS + 3;       // +/-2.0
  localparam int DER_W   = ERR_W + 1;           // err - last_err
  localparam int SUM_W   = LIM_W + 1;           // clamped integral
  localparam int SUMX_W  = SUM_W + 1;           // before clamp
  localparam int MA_W    = GAIN_W + 1;
  localparam int MB_W    = SUM_W;
  localparam int PROD_W  = MA_W + MB_W;
  localparam int ACC_W   = PROD_W - FRAC_BITS + 2;
  localparam int CMD_W   = ACC_W + 1;
  localparam int DUTY_W  = 13;
  localparam int OUT_TDATA_W = 32;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = LIM_W;

  // Reset values of the registers
  localparam logic [THR_W-1:0]  THR_RST   = THR_W'(2000);
  localparam logic [GAIN_W-1:0] KP_RST    = GAIN_W'(3277);
  localparam logic [GAIN_W-1:0] KI_RST    = GAIN_W'(82);
  localparam logic [GAIN_W-1:0] KD_RST    = GAIN_W'(2458);
  localparam logic [BASE_W-1:0] BASE_RST  = BASE_W'(2867);
  localparam logic [LIM_W-1:0]  LIM_RST   = LIM_W'(204800);

  // 0.95 in Q.12, truncated
  localparam int DECAY_NUM = (95 << FRAC_BITS) / 100;

  localparam logic signed [ERR_W-1:0] ERR_ONE = ERR_W'(1 << FRAC_BITS);
  localparam logic signed [ERR_W-1:0] ERR_TWO = ERR_W'(2 << FRAC_BITS);
  localparam logic [DUTY_W-1:0] DUTY_FULL = DUTY_W'(1 << FRAC_BITS);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_THRESHOLD  = 3'd0,
    REG_PROP_GAIN  = 3'd1,
    REG_INTEG_GAIN = 3'd2,
    REG_DERIV_GAIN = 3'd3,
    REG_BASE_SPEED = 3'd4,
    REG_INTEG_LIM  = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MUL_DECAY = 2'd0,
    MUL_PROP  = 2'd1,
    MUL_INTEG = 2'd2,
    MUL_DERIV = 2'd3
  } mul_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     class_en;
    logic     decay_en;
    logic     sum_en;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_clr;
    logic     acc_add;
    logic     load_out;
    logic     commit;
  } dp_cmd_t;

  typedef struct packed {
    logic all_off;
  } dp_status_t;

endpackage

>>> rtl/lfpd_ctrl.sv
module lfpd_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic                  in_paused,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  lfpd_pkg::dp_status_t  status,
  output lfpd_pkg::dp_cmd_t     cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CLASS = 8'b0000_0010,
    S_DECAY = 8'b0000_0100,
    S_SUM   = 8'b0000_1000,
    S_MI    = 8'b0001_0000,
    S_MD    = 8'b0010_0000,
    S_FIN   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_acc;
  logic   out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.mul_sel = lfpd_pkg::MUL_DECAY;
    case (state_r)
      S_IDLE: begin
        // paused items are taken and dropped
        if (in_acc && !in_paused) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_CLASS;
        end
      end
      S_CLASS: begin
        cmd.class_en = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = lfpd_pkg::MUL_DECAY;
        state_nxt    = status.all_off ? S_DECAY : S_SUM;
      end
      S_DECAY: begin
        cmd.decay_en = 1'b1;
        state_nxt    = S_SUM;
      end
      S_SUM: begin
        cmd.sum_en  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = lfpd_pkg::MUL_PROP;
        state_nxt   = S_MI;
      end
      S_MI: begin
        cmd.acc_clr = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = lfpd_pkg::MUL_INTEG;
        state_nxt   = S_MD;
      end
      S_MD: begin
        cmd.acc_add = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = lfpd_pkg::MUL_DERIV;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        cmd.acc_add = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          cmd.commit   = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_tready))
    else $error("pending result overwritten");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !in_paused) |=> (state_r == S_CLASS))
    else $error("unpaused item did not start");

  a_paused_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_paused) |=> (state_r == S_IDLE && !cmd.commit))
    else $error("paused item changed state");

  a_commit_with_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("commit without result");

endmodule

>>> rtl/lfpd_datapath.sv
module lfpd_datapath #(
  parameter int SAMPLE_BITS = lfpd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic [SAMPLE_BITS-1:0]                 left_level,
  input  logic [SAMPLE_BITS-1:0]                 middle_level,
  input  logic [SAMPLE_BITS-1:0]                 right_level,
  input  logic                                   cfg_we,
  input  logic [lfpd_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [lfpd_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  lfpd_pkg::dp_cmd_t                      cmd,
  output lfpd_pkg::dp_status_t                   status,
  output logic [lfpd_pkg::OUT_TDATA_W-1:0]       out_tdata
);

  localparam int CMP_W = (SAMPLE_BITS > lfpd_pkg::THR_W) ? SAMPLE_BITS : lfpd_pkg::THR_W;
  localparam int ERR_W  = lfpd_pkg::ERR_W;
  localparam int DER_W  = lfpd_pkg::DER_W;
  localparam int SUM_W  = lfpd_pkg::SUM_W;
  localparam int SUMX_W = lfpd_pkg::SUMX_W;
  localparam int MA_W   = lfpd_pkg::MA_W;
  localparam int MB_W   = lfpd_pkg::MB_W;
  localparam int PROD_W = lfpd_pkg::PROD_W;
  localparam int ACC_W  = lfpd_pkg::ACC_W;
  localparam int CMD_W  = lfpd_pkg::CMD_W;
  localparam int DUTY_W = lfpd_pkg::DUTY_W;
  localparam int FB     = lfpd_pkg::FRAC_BITS;

  // configuration registers
  logic [lfpd_pkg::THR_W-1:0]  thr_r;
  logic [lfpd_pkg::GAIN_W-1:0] kp_r, ki_r, kd_r;
  logic [lfpd_pkg::BASE_W-1:0] base_r;
  logic [lfpd_pkg::LIM_W-1:0]  lim_r;

  // controller state
  logic signed [SUM_W-1:0] error_sum_r;
  logic signed [ERR_W-1:0] last_error_r;

  // working registers
  logic [2:0]               on_r;         // {right, middle, left}
  logic signed [ERR_W-1:0]  err_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [DER_W-1:0]  deriv_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [lfpd_pkg::OUT_TDATA_W-1:0] out_r;

  logic [CMP_W-1:0]         thr_x;
  logic [2:0]               on_nxt;
  logic signed [ERR_W-1:0]  err_class;
  logic [ERR_W-1:0]         prev_mag;
  logic [ERR_W-1:0]         dec_mag;
  logic signed [ERR_W-1:0]  err_dec;
  logic signed [SUMX_W-1:0] sum_raw, lim_pos, lim_neg;
  logic signed [SUM_W-1:0]  sum_clamp;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [ACC_W-1:0]  prod_sh;
  logic signed [CMD_W-1:0]  base_x, acc_x, lcmd, rcmd;
  logic [DUTY_W-1:0]        lduty, rduty;

  function automatic logic [DUTY_W-1:0] duty_of(input logic signed [CMD_W-1:0] c);
    logic [CMD_W-1:0] mag;
    mag = c[CMD_W-1] ? CMD_W'(-c) : CMD_W'(c);
    if (mag > CMD_W'(lfpd_pkg::DUTY_FULL)) begin
      return lfpd_pkg::DUTY_FULL;
    end
    return mag[DUTY_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= lfpd_pkg::THR_RST;
      kp_r   <= lfpd_pkg::KP_RST;
      ki_r   <= lfpd_pkg::KI_RST;
      kd_r   <= lfpd_pkg::KD_RST;
      base_r <= lfpd_pkg::BASE_RST;
      lim_r  <= lfpd_pkg::LIM_RST;
    end else if (cfg_we) begin
      case (lfpd_pkg::cfg_reg_t'(cfg_addr))
        lfpd_pkg::REG_THRESHOLD:  thr_r  <= cfg_wdata[lfpd_pkg::THR_W-1:0];
        lfpd_pkg::REG_PROP_GAIN:  kp_r   <= cfg_wdata[lfpd_pkg::GAIN_W-1:0];
        lfpd_pkg::REG_INTEG_GAIN: ki_r   <= cfg_wdata[lfpd_pkg::GAIN_W-1:0];
        lfpd_pkg::REG_DERIV_GAIN: kd_r   <= cfg_wdata[lfpd_pkg::GAIN_W-1:0];
        lfpd_pkg::REG_BASE_SPEED: base_r <= cfg_wdata[lfpd_pkg::BASE_W-1:0];
        lfpd_pkg::REG_INTEG_LIM:  lim_r  <= cfg_wdata[lfpd_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // sensor compare at load time
  assign thr_x     = CMP_W'(thr_r);
  assign on_nxt[0] = CMP_W'(left_level) > thr_x;
  assign on_nxt[1] = CMP_W'(middle_level) > thr_x;
  assign on_nxt[2] = CMP_W'(right_level) > thr_x;
  assign status.all_off = (on_r == 3'b000);

  always_comb begin
    if (on_r[1]) begin
      if (on_r[0])      err_class = -lfpd_pkg::ERR_TWO;
      else if (on_r[2]) err_class = lfpd_pkg::ERR_TWO;
      else              err_class = '0;
    end else begin
      if (on_r[0])      err_class = -lfpd_pkg::ERR_ONE;
      else              err_class = lfpd_pkg::ERR_ONE;   // right only
    end
  end

  // decay on the magnitude so the result truncates toward zero
  assign prev_mag = last_error_r[ERR_W-1] ? ERR_W'(-last_error_r) : ERR_W'(last_error_r);
  assign dec_mag  = ERR_W'(prod_r >>> FB);
  assign err_dec  = last_error_r[ERR_W-1] ? -signed'(dec_mag) : signed'(dec_mag);

  assign sum_raw = SUMX_W'(error_sum_r) + SUMX_W'(err_r);
  assign lim_pos = signed'(SUMX_W'(lim_r));
  assign lim_neg = -lim_pos;
  always_comb begin
    if (sum_raw > lim_pos)      sum_clamp = SUM_W'(lim_pos);
    else if (sum_raw < lim_neg) sum_clamp = SUM_W'(lim_neg);
    else                        sum_clamp = SUM_W'(sum_raw);
  end

  always_comb begin
    case (cmd.mul_sel)
      lfpd_pkg::MUL_DECAY: begin
        mul_a = MA_W'(lfpd_pkg::DECAY_NUM);
        mul_b = signed'(MB_W'(prev_mag));
      end
      lfpd_pkg::MUL_PROP: begin
        mul_a = signed'(MA_W'(kp_r));
        mul_b = MB_W'(err_r);
      end
      lfpd_pkg::MUL_INTEG: begin
        mul_a = signed'(MA_W'(ki_r));
        mul_b = sum_r;
      end
      lfpd_pkg::MUL_DERIV: begin
        mul_a = signed'(MA_W'(kd_r));
        mul_b = MB_W'(deriv_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // arithmetic shift is floor division by 2^FB
  assign prod_sh = ACC_W'(prod_r >>> FB);

  assign base_x = signed'(CMD_W'(base_r));
  assign acc_x  = CMD_W'(acc_r);
  assign lcmd   = base_x - acc_x;
  assign rcmd   = base_x + acc_x;
  assign lduty  = duty_of(lcmd);
  assign rduty  = duty_of(rcmd);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_sum_r  <= '0;
      last_error_r <= '0;
    end else if (cmd.commit) begin
      error_sum_r  <= sum_r;
      last_error_r <= err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in)  on_r    <= on_nxt;
    if (cmd.class_en && !status.all_off) err_r <= err_class;
    if (cmd.decay_en) err_r   <= err_dec;
    if (cmd.sum_en) begin
      sum_r   <= sum_clamp;
      deriv_r <= DER_W'(err_r) - DER_W'(last_error_r);
    end
    if (cmd.mul_en)   prod_r  <= PROD_W'(mul_a * mul_b);
    if (cmd.acc_clr)  acc_r   <= prod_sh;
    else if (cmd.acc_add) acc_r <= acc_r + prod_sh;
    if (cmd.load_out) begin
      out_r <= {2'b00, rduty, !rcmd[CMD_W-1], rcmd[CMD_W-1],
                lduty, lcmd[CMD_W-1], !lcmd[CMD_W-1]};
    end
  end

  assign out_tdata = out_r;

  a_sum_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (SUMX_W'(sum_r) <= lim_pos && SUMX_W'(sum_r) >= lim_neg))
    else $error("integral outside clamp");

  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (err_r <= lfpd_pkg::ERR_TWO && err_r >= -lfpd_pkg::ERR_TWO))
    else $error("error out of range");

  a_duty_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> (out_r[14:2] <= lfpd_pkg::DUTY_FULL && out_r[29:17] <= lfpd_pkg::DUTY_FULL))
    else $error("duty above full scale");

endmodule

>>> rtl/line_follow_pid_drive_core.sv
// Channel   Dir  Handshake              Payload
// in_       in   in_tvalid/in_tready    tdata: left, middle, right level; tuser: paused
// out_      out  out_tvalid/out_tready  tdata: left pins+duty, right pins+duty
// cfg_      in   cfg_we                 cfg_addr register index, cfg_wdata value
//
// An unpaused item reaches the result register through CLASS, SUM, MI, MD, FIN and OUT,
// with DECAY after CLASS when no sensor sees the line and the last error is decayed; the
// next item is taken only once the engine is back in IDLE. One shared 17x19 multiplier does the
// decay and the three gain products in turn. A paused item is taken and dropped.
// rst_n is synchronous, active low: register defaults, integral and last error cleared.
// A stalled result holds the engine in its last step until the output register frees.
module line_follow_pid_drive_core #(
  parameter int SAMPLE_BITS = lfpd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [S-1:0] left_level, [2S-1:S] middle_level, [3S-1:2S] right_level
  input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  // [0] paused
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] left_pin_a, [1] left_pin_b, [14:2] left_duty,
  // [15] right_pin_a, [16] right_pin_b, [29:17] right_duty
  output logic [lfpd_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                              cfg_we,
  input  logic [lfpd_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [lfpd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  lfpd_pkg::dp_cmd_t    cmd;
  lfpd_pkg::dp_status_t status;

  lfpd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_paused  (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  lfpd_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .left_level   (in_tdata[SAMPLE_BITS-1:0]),
    .middle_level (in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .right_level  (in_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS]),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .cmd          (cmd),
    .status       (status),
    .out_tdata    (out_tdata)
  );

endmodule

>>> tb/sv/tb_top.sv
module tb_top;

  localparam int FRAC_BITS   = lfpd_pkg::FRAC_BITS;
  localparam int DUTY_W      = lfpd_pkg::DUTY_W;
  localparam int OUT_TDATA_W = lfpd_pkg::OUT_TDATA_W;
  localparam int CFG_ADDR_W  = lfpd_pkg::CFG_ADDR_W;
  localparam int CFG_DATA_W  = lfpd_pkg::CFG_DATA_W;
  localparam int THR_W       = lfpd_pkg::THR_W;
  localparam int GAIN_W      = lfpd_pkg::GAIN_W;
  localparam int BASE_W      = lfpd_pkg::BASE_W;
  localparam int LIM_W       = lfpd_pkg::LIM_W;
  localparam int IN_W = ((3*lfpd_pkg::SAMPLE_BITS_DEF+7)/8)*8;
  localparam longint UNIT = longint'(1) << FRAC_BITS;
  // indexes past the register list; writes there must be dropped
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_7 = 3'd7;
  localparam int N_ROWS = 23;

  typedef struct packed {
    logic              left_a;
    logic              left_b;
    logic [DUTY_W-1:0] left_duty;
    logic              right_a;
    logic              right_b;
    logic [DUTY_W-1:0] right_duty;
  } drive_t;

  typedef struct packed {
    logic [11:0] lv;
    logic [11:0] mv;
    logic [11:0] rv;
    logic        hold;
    logic        typed;
    drive_t      want;
  } probe_t;

  // straight ahead at base speed: what a fresh block gives with no line seen
  localparam drive_t CRUISE = '{1'b1, 1'b0, lfpd_pkg::BASE_RST, 1'b0, 1'b1, lfpd_pkg::BASE_RST};
  localparam drive_t NO_DRIVE = '0;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // predictor copy of the registers and the loop state
  logic [THR_W-1:0]  thr_q = lfpd_pkg::THR_RST;
  logic [GAIN_W-1:0] kp_q = lfpd_pkg::KP_RST;
  logic [GAIN_W-1:0] ki_q = lfpd_pkg::KI_RST;
  logic [GAIN_W-1:0] kd_q = lfpd_pkg::KD_RST;
  logic [BASE_W-1:0] base_q = lfpd_pkg::BASE_RST;
  logic [LIM_W-1:0]  lim_q = lfpd_pkg::LIM_RST;
  longint integ_acc = 0;
  longint prev_err = 0;

  drive_t drive_q[$];
  int mismatches = 0;
  int src_idle_pct = 0;
  int sink_idle_pct = 0;

  line_follow_pid_drive_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  task automatic flag_diff(input string what, input longint got, input longint want);
    mismatches++;
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
  endtask

  function automatic logic [DUTY_W-1:0] duty_of(input longint cmd);
    longint mag;
    mag = (cmd < 0) ? -cmd : cmd;
    if (mag > UNIT) mag = UNIT;
    return DUTY_W'(mag);
  endfunction

  // one control step: classify, integrate, PID, split into the two motors
  function automatic drive_t steer_predict(input logic [11:0] lv, mv, rv);
    longint err, mag, sum, lim, corr, lcmd, rcmd, kp, ki, kd, base;
    bit lon, mon, ron;
    drive_t res;
    lon = lv > thr_q;
    mon = mv > thr_q;
    ron = rv > thr_q;
    kp = longint'(kp_q);
    ki = longint'(ki_q);
    kd = longint'(kd_q);
    base = longint'(base_q);
    lim = longint'(lim_q);
    if (mon) begin
      err = lon ? -2 * UNIT : (ron ? 2 * UNIT : 0);
    end else if (lon) begin
      err = -UNIT;
    end else if (ron) begin
      err = UNIT;
    end else begin
      // line lost: keep steering on a shrinking copy of the last error
      mag = (prev_err < 0) ? -prev_err : prev_err;
      mag = (mag * lfpd_pkg::DECAY_NUM) >>> FRAC_BITS;
      err = (prev_err < 0) ? -mag : mag;
    end
    sum = integ_acc + err;
    if (sum > lim) sum = lim;
    if (sum < -lim) sum = -lim;
    corr = ((kp * err) >>> FRAC_BITS) + ((ki * sum) >>> FRAC_BITS)
         + ((kd * (err - prev_err)) >>> FRAC_BITS);
    lcmd = base - corr;
    rcmd = base + corr;
    res.left_a = (lcmd >= 0);
    res.left_b = (lcmd < 0);
    res.left_duty = duty_of(lcmd);
    res.right_a = (rcmd < 0);
    res.right_b = (rcmd >= 0);
    res.right_duty = duty_of(rcmd);
    integ_acc = sum;
    prev_err = err;
    return res;
  endfunction

  function automatic logic [11:0] level_for(input bit on);
    int t;
    t = int'(thr_q);
    if (on && t < 4095) begin
      return ($urandom_range(3) == 0) ? 12'(t + 1) : 12'($urandom_range(4095, t + 1));
    end
    if (!on) begin
      return ($urandom_range(3) == 0) ? 12'(t) : 12'($urandom_range(t, 0));
    end
    return 12'd4095;
  endfunction

  task automatic set_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      lfpd_pkg::REG_THRESHOLD:  thr_q = val[THR_W-1:0];
      lfpd_pkg::REG_PROP_GAIN:  kp_q = val[GAIN_W-1:0];
      lfpd_pkg::REG_INTEG_GAIN: ki_q = val[GAIN_W-1:0];
      lfpd_pkg::REG_DERIV_GAIN: kd_q = val[GAIN_W-1:0];
      lfpd_pkg::REG_BASE_SPEED: base_q = val[BASE_W-1:0];
      lfpd_pkg::REG_INTEG_LIM:  lim_q = val[LIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [CFG_DATA_W-1:0] thr, kp, ki, kd, base, lim);
    set_reg(lfpd_pkg::REG_THRESHOLD, thr);
    set_reg(lfpd_pkg::REG_PROP_GAIN, kp);
    set_reg(lfpd_pkg::REG_INTEG_GAIN, ki);
    set_reg(lfpd_pkg::REG_DERIV_GAIN, kd);
    set_reg(lfpd_pkg::REG_BASE_SPEED, base);
    set_reg(lfpd_pkg::REG_INTEG_LIM, lim);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic feed(input logic [11:0] lv, mv, rv, input bit pz,
                      input bit typed = 1'b0, input drive_t want = '0);
    drive_t calc;
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_W'({rv, mv, lv});
    in_tuser <= pz;
    do @(posedge clk); while (!in_tready);
    if (!pz) begin
      calc = steer_predict(lv, mv, rv);
      drive_q.push_back(typed ? want : calc);
    end
  endtask

  // stop sending, let every pending result out, then give a paused item time to clear
  task automatic drain_pipeline();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic run_traffic(input int target);
    int sent, chunk, kind, k;
    logic [11:0] lv, mv, rv;
    bit pz;
    sent = 0;
    while (sent < target) begin
      kind = $urandom_range(5);
      chunk = $urandom_range(30, 4);
      for (k = 0; k < chunk && sent < target; k++) begin
        pz = ($urandom_range(99) < 8);
        case (kind)
          0: begin
            lv = 12'($urandom_range(4095));
            mv = 12'($urandom_range(4095));
            rv = 12'($urandom_range(4095));
          end
          1: begin  // drifting right of the line
            lv = level_for(1'b1);
            mv = level_for(1'($urandom_range(1)));
            rv = level_for(1'($urandom_range(1)));
          end
          2: begin
            lv = level_for(1'b0);
            mv = level_for(1'($urandom_range(1)));
            rv = level_for(1'b1);
          end
          3: begin  // line lost, error decays
            lv = level_for(1'b0);
            mv = level_for(1'b0);
            rv = level_for(1'b0);
          end
          4: begin
            lv = level_for(1'($urandom_range(1)));
            mv = level_for(1'b1);
            rv = level_for(1'($urandom_range(1)));
          end
          default: begin
            lv = level_for(1'($urandom_range(1)));
            mv = level_for(1'($urandom_range(1)));
            rv = level_for(1'($urandom_range(1)));
          end
        endcase
        feed(lv, mv, rv, pz);
        if (!pz) sent++;
      end
    end
  endtask

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    drive_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.left_a = out_tdata[0];
      got.left_b = out_tdata[1];
      got.left_duty = out_tdata[14:2];
      got.right_a = out_tdata[15];
      got.right_b = out_tdata[16];
      got.right_duty = out_tdata[29:17];
      if (drive_q.size() == 0) begin
        flag_diff("item with nothing pending, left_duty", longint'(got.left_duty), -1);
      end else begin
        want = drive_q.pop_front();
        if (got.left_a !== want.left_a)
          flag_diff("left_pin_a", longint'(got.left_a), longint'(want.left_a));
        if (got.left_b !== want.left_b)
          flag_diff("left_pin_b", longint'(got.left_b), longint'(want.left_b));
        if (got.left_duty !== want.left_duty)
          flag_diff("left_duty", longint'(got.left_duty), longint'(want.left_duty));
        if (got.right_a !== want.right_a)
          flag_diff("right_pin_a", longint'(got.right_a), longint'(want.right_a));
        if (got.right_b !== want.right_b)
          flag_diff("right_pin_b", longint'(got.right_b), longint'(want.right_b));
        if (got.right_duty !== want.right_duty)
          flag_diff("right_duty", longint'(got.right_duty), longint'(want.right_duty));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    probe_t steer_rows [N_ROWS];
    int i;
    steer_rows = '{
      '{12'd0,    12'd0,    12'd0,    1'b0, 1'b1, CRUISE},
      '{12'd4095, 12'd4095, 12'd4095, 1'b1, 1'b0, NO_DRIVE},  // paused, state held
      '{12'd0,    12'd0,    12'd0,    1'b0, 1'b1, CRUISE},
      '{12'd4095, 12'd4095, 12'd0,    1'b0, 1'b0, NO_DRIVE},
      '{12'd4095, 12'd4095, 12'd4095, 1'b0, 1'b0, NO_DRIVE},
      '{12'd0,    12'd4095, 12'd4095, 1'b0, 1'b0, NO_DRIVE},
      '{12'd0,    12'd4095, 12'd0,    1'b0, 1'b0, NO_DRIVE},
      '{12'd2001, 12'd2000, 12'd0,    1'b0, 1'b0, NO_DRIVE},  // level equal to threshold is off
      '{12'd4095, 12'd0,    12'd4095, 1'b0, 1'b0, NO_DRIVE},
      '{12'd2000, 12'd2000, 12'd2001, 1'b0, 1'b0, NO_DRIVE},
      '{12'd0,    12'd0,    12'd0,    1'b0, 1'b0, NO_DRIVE},
      '{12'd2000, 12'd1999, 12'd2000, 1'b0, 1'b0, NO_DRIVE},
      '{12'd0,    12'd0,    12'd0,    1'b0, 1'b0, NO_DRIVE},
      '{12'd4095, 12'd0,    12'd0,    1'b1, 1'b0, NO_DRIVE},
      '{12'd0,    12'd0,    12'd0,    1'b0, 1'b0, NO_DRIVE},
      '{12'd0,    12'd2001, 12'd2001, 1'b0, 1'b0, NO_DRIVE},
      '{12'd2001, 12'd2001, 12'd0,    1'b0, 1'b0, NO_DRIVE},
      '{12'd4095, 12'd4095, 12'd0,    1'b0, 1'b0, NO_DRIVE},
      '{12'd0,    12'd0,    12'd4095, 1'b0, 1'b0, NO_DRIVE},
      '{12'd0,    12'd0,    12'd0,    1'b0, 1'b0, NO_DRIVE},
      '{12'd1,    12'd4094, 12'd1,    1'b0, 1'b0, NO_DRIVE},
      '{12'hAAA,  12'h555,  12'hAAA,  1'b0, 1'b0, NO_DRIVE},
      '{12'h555,  12'hAAA,  12'h555,  1'b0, 1'b0, NO_DRIVE}
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    src_idle_pct = 21;
    sink_idle_pct = 48;
    for (i = 0; i < N_ROWS; i++) begin
      feed(steer_rows[i].lv, steer_rows[i].mv, steer_rows[i].rv, steer_rows[i].hold,
           steer_rows[i].typed, steer_rows[i].want);
    end
    run_traffic(150);
    drain_pipeline();

    // zero threshold, hard P and D, no integral; high bits on threshold and base are masked
    set_reg(REG_SPARE_6, 18'h00ABC);
    set_reg(REG_SPARE_7, 18'h3FFFF);
    apply_setting(18'h3F000, 18'hFFFF, 18'h0, 18'hFFFF, 18'h3F000 | 18'd4096, 18'd0);
    run_traffic(150);
    drain_pipeline();

    // sensors can never exceed the top threshold: pure decay
    apply_setting(18'd4095, 18'd0, 18'hFFFF, 18'd0, 18'd0, 18'h3FFFF);
    run_traffic(40);
    drain_pipeline();

    src_idle_pct = 48;
    sink_idle_pct = 21;
    apply_setting(CFG_DATA_W'($urandom_range(3000, 800)), CFG_DATA_W'($urandom),
                  CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), 18'h1FFF,
                  CFG_DATA_W'($urandom_range(20000, 0)));
    run_traffic(140);
    drain_pipeline();

    apply_setting(CFG_DATA_W'($urandom_range(3500, 500)), CFG_DATA_W'($urandom),
                  CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                  CFG_DATA_W'($urandom));
    run_traffic(140);
    drain_pipeline();

    src_idle_pct = 0;
    sink_idle_pct = 0;
    apply_setting(CFG_DATA_W'($urandom_range(3500, 500)), CFG_DATA_W'($urandom_range(8000, 0)),
                  CFG_DATA_W'($urandom_range(2000, 0)), CFG_DATA_W'($urandom_range(8000, 0)),
                  CFG_DATA_W'($urandom_range(4096, 0)), CFG_DATA_W'($urandom_range(60000, 0)));
    run_traffic(140);
    drain_pipeline();

    apply_setting(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                  CFG_DATA_W'($urandom_range(300, 0)), CFG_DATA_W'($urandom),
                  CFG_DATA_W'($urandom_range(4096, 0)),
                  CFG_DATA_W'($urandom_range(262143, 100000)));
    run_traffic(140);
    drain_pipeline();

    apply_setting(CFG_DATA_W'(lfpd_pkg::THR_RST), CFG_DATA_W'(lfpd_pkg::KP_RST),
                  CFG_DATA_W'(lfpd_pkg::KI_RST), CFG_DATA_W'(lfpd_pkg::KD_RST),
                  CFG_DATA_W'(lfpd_pkg::BASE_RST), CFG_DATA_W'(lfpd_pkg::LIM_RST));
    run_traffic(140);
    drain_pipeline();

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
